/* design/sui_pkg.sv */
// types and fixed constants for the set union / intersection block
// used by sui_ram and set_union_intersection, depends on nothing
`default_nettype none

package sui_pkg;

   localparam int DATA_W  = 32;
   localparam int MATCH_W = 5;

   localparam logic [1:0] FUNC_LOAD_A    = 2'd0;
   localparam logic [1:0] FUNC_PRESENT_B = 2'd1;
   localparam logic [1:0] FUNC_CLEAR     = 2'd2;

   localparam logic [MATCH_W-1:0] MATCH_MAX = '1;

   typedef struct packed {
      logic [1:0]               func;
      logic signed [DATA_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] echo_value;
      logic                     in_union;
      logic [MATCH_W-1:0]       match_count;
      logic                     overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

/* design/sui_ram.sv */
// single write port, single read port synchronous ram with registered read data
// depends on sui_pkg for the word width
`default_nettype none

module sui_ram #(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [sui_pkg::DATA_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [sui_pkg::DATA_W-1:0] rd_data
);
   import sui_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/set_union_intersection.sv */
// set union / intersection top level: sequencer, counters and response register
// depends on sui_pkg and sui_ram
//
// usage: drive req_word and raise start; the word is taken at a rising edge
// where start is high and busy is low. every word gives exactly one response
// word on rsp_word, marked by rsp_strobe for one cycle; the receiver cannot
// stall it. func 0 appends to the A store and the union list, func 1 presents
// a B element, func 2 clears both stores.
// A loads, clears and dropped words answer in the cycle after they are taken,
// and busy stays low so a new word may follow at once.
// a B element scans both memories in parallel, one address a cycle, over
// max(a entries, union entries) addresses; the response follows the scan
// through the drain and result states, with busy high until then.
// the A count never exceeds the union count, so the scan covers at most
// UNION_DEPTH addresses; the single read port of each ram sets that pace.
// reset empties both stores and all counts at once; no clearing pass is run.
`default_nettype none

module set_union_intersection #(
   parameter int A_DEPTH     = 16,
   parameter int B_DEPTH     = 16,
   parameter int UNION_DEPTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire sui_pkg::req_type req_word,
   output logic                  rsp_strobe,
   output sui_pkg::rsp_type      rsp_word
);
   import sui_pkg::*;

   localparam int AAW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int UAW = (UNION_DEPTH > 1) ? $clog2(UNION_DEPTH) : 1;
   localparam int ACW = $clog2(A_DEPTH + 1);
   localparam int UCW = $clog2(UNION_DEPTH + 1);
   localparam int BCW = $clog2(B_DEPTH + 1);
   localparam int SCW = (ACW > UCW) ? ACW : UCW;

   state_type          state_ff, state_in;
   logic [ACW-1:0]     a_count_ff, a_count_in;
   logic [UCW-1:0]     union_count_ff, union_count_in;
   logic [BCW-1:0]     b_count_ff, b_count_in;
   logic [SCW-1:0]     idx_ff, idx_in;
   logic [DATA_W-1:0]  value_ff, value_in;
   logic [MATCH_W-1:0] match_ff, match_in;
   logic               found_ff, found_in;
   logic               a_vld_ff, a_vld_in;
   logic               u_vld_ff, u_vld_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_word_ff, rsp_word_in;

   logic               rd_en;
   logic               a_wr_en;
   logic               u_wr_en;
   logic [DATA_W-1:0]  wr_data;
   logic [DATA_W-1:0]  a_rd_data;
   logic [DATA_W-1:0]  u_rd_data;
   logic [SCW-1:0]     a_bound;
   logic [SCW-1:0]     u_bound;

   assign a_bound = SCW'(a_count_ff);
   assign u_bound = SCW'(union_count_ff);

   sui_ram #(.DEPTH(A_DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_count_ff[AAW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AAW-1:0]),
      .rd_data (a_rd_data)
   );

   sui_ram #(.DEPTH(UNION_DEPTH)) u_union_ram (
      .clock   (clock),
      .wr_en   (u_wr_en),
      .wr_addr (union_count_ff[UAW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[UAW-1:0]),
      .rd_data (u_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         a_count_ff     <= '0;
         union_count_ff <= '0;
         b_count_ff     <= '0;
         a_vld_ff       <= 1'b0;
         u_vld_ff       <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         a_count_ff     <= a_count_in;
         union_count_ff <= union_count_in;
         b_count_ff     <= b_count_in;
         a_vld_ff       <= a_vld_in;
         u_vld_ff       <= u_vld_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      value_ff    <= value_in;
      match_ff    <= match_in;
      found_ff    <= found_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      state_in       = state_ff;
      a_count_in     = a_count_ff;
      union_count_in = union_count_ff;
      b_count_in     = b_count_ff;
      idx_in         = idx_ff;
      value_in       = value_ff;
      match_in       = match_ff;
      found_in       = found_ff;
      a_vld_in       = 1'b0;
      u_vld_in       = 1'b0;
      rsp_strobe_in  = 1'b0;
      rsp_word_in    = rsp_word_ff;
      rd_en          = 1'b0;
      a_wr_en        = 1'b0;
      u_wr_en        = 1'b0;
      wr_data        = value_ff;

      // compare stage on the registered read data
      if (a_vld_ff && a_rd_data == value_ff && match_ff != MATCH_MAX) begin
         match_in = match_ff + 1'b1;
      end
      if (u_vld_ff && u_rd_data == value_ff) begin
         found_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in      = req_word.element_value;
               wr_data       = req_word.element_value;
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '0;
               case (req_word.func)
                  FUNC_LOAD_A: begin
                     rsp_word_in.echo_value = req_word.element_value;
                     if (a_count_ff < ACW'(A_DEPTH) &&
                         union_count_ff < UCW'(UNION_DEPTH)) begin
                        a_wr_en              = 1'b1;
                        u_wr_en              = 1'b1;
                        a_count_in           = a_count_ff + 1'b1;
                        union_count_in       = union_count_ff + 1'b1;
                        rsp_word_in.in_union = 1'b1;
                     end else begin
                        rsp_word_in.overflow = 1'b1;
                     end
                  end
                  FUNC_PRESENT_B: begin
                     rsp_word_in.echo_value = req_word.element_value;
                     if (b_count_ff == BCW'(B_DEPTH)) begin
                        rsp_word_in.overflow = 1'b1;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        rsp_word_in   = rsp_word_ff;
                        b_count_in    = b_count_ff + 1'b1;
                        match_in      = '0;
                        found_in      = 1'b0;
                        idx_in        = '0;
                        state_in      = ST_SCAN;
                     end
                  end
                  FUNC_CLEAR: begin
                     a_count_in     = '0;
                     union_count_in = '0;
                     b_count_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (idx_ff < a_bound || idx_ff < u_bound) begin
               rd_en    = 1'b1;
               a_vld_in = idx_ff < a_bound;
               u_vld_in = idx_ff < u_bound;
               idx_in   = idx_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            rsp_strobe_in           = 1'b1;
            rsp_word_in             = '0;
            rsp_word_in.echo_value  = value_ff;
            rsp_word_in.match_count = match_ff;
            if (!found_ff) begin
               if (union_count_ff < UCW'(UNION_DEPTH)) begin
                  u_wr_en              = 1'b1;
                  union_count_in       = union_count_ff + 1'b1;
                  rsp_word_in.in_union = 1'b1;
               end else begin
                  rsp_word_in.overflow = 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      a_count_ff <= ACW'(A_DEPTH))
      else $error("a count beyond capacity");

   union_count_bound: assert property (@(posedge clock) disable iff (reset)
      union_count_ff <= UCW'(UNION_DEPTH))
      else $error("union count beyond capacity");

   rsp_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !(rsp_word_ff.in_union && rsp_word_ff.overflow))
      else $error("appended and overflow in one response");

   scan_only_for_b: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_word.func == FUNC_PRESENT_B))
      else $error("scan started without a b element");

   no_write_while_scanning: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !(a_wr_en || u_wr_en))
      else $error("memory written during a scan");

endmodule

`default_nettype wire
